[rtl/fra_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fra_pkg: shared types and constants
// Sizes of the tree stores, beat field widths and the memory port bundle.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);
  localparam int unsigned POS_W   = ADDR_W + 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned DATA_W  = 32;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

[rtl/fra_tree_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fra_tree_ram: tree node store
// One write and one read port, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module fra_tree_ram (
  input  wire logic                      clk_i,
  input  wire fra_pkg::ram_req_t         req_i,
  output logic [fra_pkg::DATA_W-1:0]     rdata_o
);

  logic [fra_pkg::DATA_W-1:0] mem_q [fra_pkg::ENTRIES];
  logic [fra_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/fra_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fra_mul: shared multiplier
// 32x32 multiply keeping the low word, product held until the next enable.
// ----------------------------------------------------------------------------
module fra_mul (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [fra_pkg::DATA_W-1:0] a_i,
  input  wire logic [fra_pkg::DATA_W-1:0] b_i,
  output logic [fra_pkg::DATA_W-1:0]     p_o
);

  logic [fra_pkg::DATA_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= fra_pkg::DATA_W'(a_i * b_i);
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

[rtl/fenwick_range_add_range_sum.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fenwick_range_add_range_sum: range add / range sum over 1024 positions
// Two Fenwick trees (difference array and weighted difference array) walked
// by one sequencer that shares a single multiplier.
// ----------------------------------------------------------------------------
// After reset the block clears both tree stores, one node per cycle, before
// it takes its first beat. An add beat has the accepting step and, for each
// of its two bound points, a multiply step, a read then a write back per tree
// node on the upward walk and a step that ends the walk. A query beat streams
// one node read per cycle down each prefix walk, followed by the multiply and
// subtract for that bound, and a finish step returns the result. Each node of
// the add walk is a read-modify-write on the tree stores. Only queries return
// a result beat; the block goes on with the next beat while that result waits
// in its register.
// ----------------------------------------------------------------------------
module fenwick_range_add_range_sum (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [9:0] first_index, [19:10] last_index, [51:20] add_value, [55:52] zero
  input  wire logic [55:0] s_axis_tdata_i,
  // [0] operation
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [31:0] range_sum
  output logic [31:0]      m_axis_tdata_o
);

  localparam int unsigned STATE_W = 4;
  localparam logic [STATE_W-1:0] S_CLEAR   = 4'd0;
  localparam logic [STATE_W-1:0] S_IDLE    = 4'd1;
  localparam logic [STATE_W-1:0] S_ADD_MUL = 4'd2;
  localparam logic [STATE_W-1:0] S_WALK_RD = 4'd3;
  localparam logic [STATE_W-1:0] S_WALK_WR = 4'd4;
  localparam logic [STATE_W-1:0] S_Q_WALK  = 4'd5;
  localparam logic [STATE_W-1:0] S_Q_MUL   = 4'd6;
  localparam logic [STATE_W-1:0] S_Q_SUB   = 4'd7;
  localparam logic [STATE_W-1:0] S_Q_FIN   = 4'd8;

  localparam int unsigned POS_W  = fra_pkg::POS_W;
  localparam int unsigned ADDR_W = fra_pkg::ADDR_W;
  localparam int unsigned DATA_W = fra_pkg::DATA_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(fra_pkg::ENTRIES);

  logic [STATE_W-1:0] state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [POS_W-1:0]   lo_q, lo_d, hi_q, hi_d, n_q, n_d;
  logic [DATA_W-1:0]  v_q, v_d;
  logic               pt_q, pt_d;
  logic               rd_pend_q, rd_pend_d;
  logic [DATA_W-1:0]  acc_d_q, acc_d_d, acc_w_q, acc_w_d, ps_q, ps_d;
  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  out_data_q, out_data_d;

  fra_pkg::ram_req_t  ram_d_req, ram_w_req;
  logic [DATA_W-1:0]  ram_d_rdata, ram_w_rdata;

  logic               mul_en;
  logic [DATA_W-1:0]  mul_a, mul_b, mul_p;

  logic               in_acc;
  logic [POS_W-1:0]   lo_in, hi_in, n_low, n_addr;
  logic [DATA_W-1:0]  neg_v, pref;

  function automatic logic [POS_W-1:0] clamp_pos(input logic [fra_pkg::IDX_W-1:0] idx);
    logic [POS_W-1:0] ix;
    ix = POS_W'(idx);
    if (ix > POS_MAX - POS_W'(1)) begin
      ix = POS_MAX - POS_W'(1);
    end
    return ix + POS_W'(1);
  endfunction

  fra_tree_ram u_diff_ram (
    .clk_i  (clk_i),
    .req_i  (ram_d_req),
    .rdata_o(ram_d_rdata)
  );

  fra_tree_ram u_wgt_ram (
    .clk_i  (clk_i),
    .req_i  (ram_w_req),
    .rdata_o(ram_w_rdata)
  );

  fra_mul u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign lo_in           = clamp_pos(s_axis_tdata_i[9:0]);
  assign hi_in           = clamp_pos(s_axis_tdata_i[19:10]);
  assign neg_v           = ~v_q + DATA_W'(1);
  assign n_low           = n_q & (~n_q + POS_W'(1));
  assign n_addr          = n_q - POS_W'(1);
  assign pref            = mul_p - acc_w_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    n_d         = n_q;
    v_d         = v_q;
    pt_d        = pt_q;
    rd_pend_d   = rd_pend_q;
    acc_d_d     = acc_d_q;
    acc_w_d     = acc_w_q;
    ps_d        = ps_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    ram_d_req       = '0;
    ram_w_req       = '0;
    ram_d_req.raddr = n_addr[ADDR_W-1:0];
    ram_w_req.raddr = n_addr[ADDR_W-1:0];
    ram_d_req.waddr = n_addr[ADDR_W-1:0];
    ram_w_req.waddr = n_addr[ADDR_W-1:0];

    mul_en = 1'b0;
    mul_a  = pt_q ? DATA_W'(hi_q) : DATA_W'(lo_q - POS_W'(1));
    mul_b  = pt_q ? neg_v : v_q;

    if (m_axis_tvalid_o && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_d_req.we    = 1'b1;
        ram_w_req.we    = 1'b1;
        ram_d_req.waddr = clr_q;
        ram_w_req.waddr = clr_q;
        clr_d           = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(fra_pkg::ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          lo_d      = lo_in;
          hi_d      = hi_in;
          v_d       = s_axis_tdata_i[51:20];
          pt_d      = 1'b0;
          rd_pend_d = 1'b0;
          acc_d_d   = '0;
          acc_w_d   = '0;
          if (s_axis_tuser_i == fra_pkg::OP_ADD) begin
            state_d = S_ADD_MUL;
          end else begin
            n_d     = hi_in;
            state_d = S_Q_WALK;
          end
        end
      end
      S_ADD_MUL: begin
        mul_en  = 1'b1;
        n_d     = pt_q ? hi_q + POS_W'(1) : lo_q;
        state_d = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (n_q > POS_MAX || n_q == '0) begin
          if (!pt_q) begin
            pt_d    = 1'b1;
            state_d = S_ADD_MUL;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          ram_d_req.re = 1'b1;
          ram_w_req.re = 1'b1;
          state_d      = S_WALK_WR;
        end
      end
      S_WALK_WR: begin
        ram_d_req.we    = 1'b1;
        ram_w_req.we    = 1'b1;
        ram_d_req.wdata = ram_d_rdata + (pt_q ? neg_v : v_q);
        ram_w_req.wdata = ram_w_rdata + mul_p;
        n_d             = n_q + n_low;
        state_d         = S_WALK_RD;
      end
      S_Q_WALK: begin
        if (rd_pend_q) begin
          acc_d_d = acc_d_q + ram_d_rdata;
          acc_w_d = acc_w_q + ram_w_rdata;
        end
        if (n_q != '0) begin
          ram_d_req.re = 1'b1;
          ram_w_req.re = 1'b1;
          n_d          = n_q - n_low;
          rd_pend_d    = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            state_d = S_Q_MUL;
          end
        end
      end
      S_Q_MUL: begin
        mul_en  = 1'b1;
        mul_a   = pt_q ? DATA_W'(lo_q - POS_W'(1)) : DATA_W'(hi_q);
        mul_b   = acc_d_q;
        state_d = S_Q_SUB;
      end
      S_Q_SUB: begin
        if (!pt_q) begin
          ps_d      = pref;
          pt_d      = 1'b1;
          n_d       = lo_q - POS_W'(1);
          acc_d_d   = '0;
          acc_w_d   = '0;
          rd_pend_d = 1'b0;
          state_d   = S_Q_WALK;
        end else begin
          ps_d    = ps_q - pref;
          state_d = S_Q_FIN;
        end
      end
      S_Q_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = ps_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pt_q        <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pt_q        <= pt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    n_q        <= n_d;
    v_q        <= v_d;
    acc_d_q    <= acc_d_d;
    acc_w_q    <= acc_w_d;
    ps_q       <= ps_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == S_Q_FIN)
    else $error("result beat raised outside the query finish step");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK_WR |-> (n_q != '0 && n_q <= POS_MAX))
    else $error("tree update walked outside the store");

  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(state_q) == S_Q_WALK)
    else $error("pending node read without a prefix walk");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR || state_q == S_WALK_WR) |-> !s_axis_tready_o)
    else $error("input taken while clearing or updating");

endmodule
`default_nettype wire

[tb/fenwick_range_add_range_sum_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_range_add_range_sum_tb: range add / range sum self-checking bench
// Drives add and query beats into the stream input and keeps a shadow pair of
// Fenwick trees. Each query accepted pushes its expected sum, and every output
// beat is compared with the oldest one. Phases cover no idling, sender gaps,
// receiver stalls, both at once, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module fenwick_range_add_range_sum_tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned END_SETTLE     = 100;

  typedef struct packed {
    logic                       op;
    logic [fra_pkg::IDX_W-1:0]  first;
    logic [fra_pkg::IDX_W-1:0]  last;
    logic [fra_pkg::DATA_W-1:0] value;
  } range_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  logic [fra_pkg::DATA_W-1:0] diff_nodes     [1:fra_pkg::ENTRIES];
  logic [fra_pkg::DATA_W-1:0] weighted_nodes [1:fra_pkg::ENTRIES];
  logic [fra_pkg::DATA_W-1:0] expected_sums  [$];

  int unsigned errors;
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned query_pct;
  int unsigned hold_left;
  int unsigned stall_cycles;
  bit          hold_request;

  fenwick_range_add_range_sum u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // shadow trees, one-based positions
  function automatic void node_add(input bit weighted, input logic [31:0] pos,
                                   input logic [fra_pkg::DATA_W-1:0] v);
    logic [31:0] n;
    n = pos;
    while (n >= 1 && n <= fra_pkg::ENTRIES) begin
      if (weighted) begin
        weighted_nodes[n] = weighted_nodes[n] + v;
      end else begin
        diff_nodes[n] = diff_nodes[n] + v;
      end
      n = n + (n & (~n + 32'd1));
    end
  endfunction

  function automatic logic [fra_pkg::DATA_W-1:0] node_prefix(input bit weighted,
                                                             input logic [31:0] pos);
    logic [31:0]                n;
    logic [fra_pkg::DATA_W-1:0] acc;
    n   = (pos > fra_pkg::ENTRIES) ? fra_pkg::ENTRIES : pos;
    acc = '0;
    while (n != 0) begin
      acc = acc + (weighted ? weighted_nodes[n] : diff_nodes[n]);
      n   = n - (n & (~n + 32'd1));
    end
    return acc;
  endfunction

  function automatic logic [fra_pkg::DATA_W-1:0] prefix_total(input logic [31:0] k);
    logic [fra_pkg::DATA_W-1:0] prod;
    prod = k * node_prefix(1'b0, k);
    return prod - node_prefix(1'b1, k);
  endfunction

  function automatic void predict_beat(input range_beat_t b);
    logic [31:0]                lo;
    logic [31:0]                hi;
    logic [fra_pkg::DATA_W-1:0] neg;
    logic [fra_pkg::DATA_W-1:0] scaled;
    lo = {22'd0, b.first} + 32'd1;
    hi = {22'd0, b.last} + 32'd1;
    if (b.op == fra_pkg::OP_ADD) begin
      neg = ~b.value + 32'd1;
      node_add(1'b0, lo, b.value);
      node_add(1'b0, hi + 32'd1, neg);
      scaled = (lo - 32'd1) * b.value;
      node_add(1'b1, lo, scaled);
      scaled = hi * neg;
      node_add(1'b1, hi + 32'd1, scaled);
    end else begin
      expected_sums.push_back(prefix_total(hi) - prefix_total(lo - 32'd1));
    end
  endfunction

  function automatic range_beat_t make_beat(input logic op, input int unsigned first,
                                            input int unsigned last,
                                            input logic [fra_pkg::DATA_W-1:0] value);
    range_beat_t b;
    b.op    = op;
    b.first = first[fra_pkg::IDX_W-1:0];
    b.last  = last[fra_pkg::IDX_W-1:0];
    b.value = value;
    return b;
  endfunction

  function automatic range_beat_t random_beat();
    range_beat_t b;
    int unsigned a;
    int unsigned c;
    b.op = ($urandom_range(0, 99) < query_pct) ? fra_pkg::OP_QUERY : fra_pkg::OP_ADD;
    a = $urandom_range(0, fra_pkg::ENTRIES - 1);
    c = $urandom_range(0, fra_pkg::ENTRIES - 1);
    case ($urandom_range(0, 11))
      0: begin b.first = '0; b.last = c[fra_pkg::IDX_W-1:0]; end
      1: begin b.first = a[fra_pkg::IDX_W-1:0]; b.last = '1; end
      2: begin b.first = a[fra_pkg::IDX_W-1:0]; b.last = a[fra_pkg::IDX_W-1:0]; end
      3, 4: begin
        b.first = (a > c) ? a[fra_pkg::IDX_W-1:0] : c[fra_pkg::IDX_W-1:0];
        b.last  = (a > c) ? c[fra_pkg::IDX_W-1:0] : a[fra_pkg::IDX_W-1:0];
      end
      default: begin
        b.first = (a < c) ? a[fra_pkg::IDX_W-1:0] : c[fra_pkg::IDX_W-1:0];
        b.last  = (a < c) ? c[fra_pkg::IDX_W-1:0] : a[fra_pkg::IDX_W-1:0];
      end
    endcase
    case ($urandom_range(0, 9))
      0: b.value = 32'h7fff_ffff;
      1: b.value = 32'h8000_0000;
      2: b.value = $urandom_range(0, 31) - 16;
      default: b.value = $urandom;
    endcase
    return b;
  endfunction

  // one beat on the input; valid stays high if the next beat follows at once
  task automatic send_beat(input range_beat_t b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.op;
    s_axis_tdata  <= {4'd0, b.value, b.last, b.first};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_beat(random_beat());
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_sums.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_beat(make_beat(fra_pkg::OP_QUERY, 0, fra_pkg::ENTRIES - 1, 32'hdead_beef));
    send_beat(make_beat(fra_pkg::OP_ADD, 0, fra_pkg::ENTRIES - 1, 32'h7fff_ffff));
    send_beat(make_beat(fra_pkg::OP_QUERY, 0, fra_pkg::ENTRIES - 1, 32'h0));
    send_beat(make_beat(fra_pkg::OP_ADD, 0, 0, 32'h8000_0000));
    send_beat(make_beat(fra_pkg::OP_QUERY, 0, 0, 32'hffff_ffff));
    // last position: update past the end is dropped
    send_beat(make_beat(fra_pkg::OP_ADD, fra_pkg::ENTRIES - 1, fra_pkg::ENTRIES - 1,
                        32'h0000_0005));
    send_beat(make_beat(fra_pkg::OP_QUERY, fra_pkg::ENTRIES - 1, fra_pkg::ENTRIES - 1,
                        32'h0));
    send_beat(make_beat(fra_pkg::OP_ADD, 500, fra_pkg::ENTRIES - 1, 32'hffff_ffff));
    send_beat(make_beat(fra_pkg::OP_QUERY, 400, fra_pkg::ENTRIES - 1, 32'h0));
    // equal pair, single position
    send_beat(make_beat(fra_pkg::OP_ADD, 37, 37, 32'h0123_4567));
    send_beat(make_beat(fra_pkg::OP_QUERY, 37, 37, 32'h0));
    send_beat(make_beat(fra_pkg::OP_QUERY, 36, 38, 32'h0));
    // reversed ranges
    send_beat(make_beat(fra_pkg::OP_ADD, 700, 300, 32'h0000_1000));
    send_beat(make_beat(fra_pkg::OP_QUERY, 300, 700, 32'h0));
    send_beat(make_beat(fra_pkg::OP_QUERY, 900, 100, 32'h0));
    send_beat(make_beat(fra_pkg::OP_QUERY, fra_pkg::ENTRIES - 1, 0, 32'h0));
    send_beat(make_beat(fra_pkg::OP_ADD, 682, 341, 32'haaaa_5555));
    send_beat(make_beat(fra_pkg::OP_QUERY, 341, 682, 32'h5555_aaaa));
    send_beat(make_beat(fra_pkg::OP_ADD, 1, fra_pkg::ENTRIES - 2, 32'h0000_0000));
    send_beat(make_beat(fra_pkg::OP_QUERY, 1, fra_pkg::ENTRIES - 2, 32'h0));
    send_beat(make_beat(fra_pkg::OP_QUERY, 0, fra_pkg::ENTRIES - 1, 32'h0));
    wait_drained();
  endtask

  task automatic test_streaming();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_random(250);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct = 86;
    recv_stall_pct  = 0;
    send_random(190);
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct = 0;
    recv_stall_pct  = 86;
    send_random(190);
  endtask

  task automatic test_mixed_idling();
    sender_idle_pct = 16;
    recv_stall_pct  = 16;
    send_random(190);
  endtask

  // output held off while queries keep coming: input must back up
  task automatic test_output_hold();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    query_pct       = 80;
    hold_request    = 1'b1;
    send_random(40);
    query_pct       = 50;
  endtask

  // drain completely between two bursts
  task automatic test_drain_pause();
    sender_idle_pct = 16;
    recv_stall_pct  = 16;
    send_random(90);
    wait_drained();
    send_random(90);
  endtask

  // output ready, with stalls and the long hold-off
  initial begin
    m_axis_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // accepted beats: check results, then track inputs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected range_sum beat, expected none, actual %h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          if (m_axis_tdata !== expected_sums[0]) begin
            $display("%0t: range_sum mismatch, expected %h, actual %h",
                     $time, expected_sums[0], m_axis_tdata);
            errors++;
          end
          void'(expected_sums.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(make_beat(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[19:10],
                               s_axis_tdata[51:20]));
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    errors          = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    query_pct       = 50;
    hold_request    = 1'b0;
    for (int i = 1; i <= fra_pkg::ENTRIES; i++) begin
      diff_nodes[i]     = '0;
      weighted_nodes[i] = '0;
    end
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= fra_pkg::OP_ADD;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_output_hold();
    test_drain_pause();

    wait_drained();
    repeat (END_SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
